// File: design/multichannel_block_averager_top_assert.svh
// Assertion macros for the multichannel block averager.
`ifndef MULTICHANNEL_BLOCK_AVERAGER_TOP_ASSERT_SVH
`define MULTICHANNEL_BLOCK_AVERAGER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define MCBA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define MCBA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: design/mcba_pkg.sv
// Shared types and constants of the multichannel block averager.
`timescale 1ns / 1ps
package mcba_pkg;

   localparam int CHAN_WIDTH       = 3;
   localparam int SAMPLE_WIDTH     = 12;
   localparam int SUM_WIDTH        = 24;
   localparam int COUNT_WIDTH      = 8;
   localparam int MEAN_WIDTH       = 16;
   localparam int MEAN_SHIFT       = 15;
   localparam int AVG_WIDTH        = 31;
   localparam int NUM_CHANNELS_DEF = 8;
   localparam int REQ_TDATA_WIDTH  = 16;
   localparam int RSP_TDATA_WIDTH  = 40;
   localparam int DIV_CNT_WIDTH    = $clog2(SUM_WIDTH + 1);

   localparam logic [COUNT_WIDTH-1:0] BLOCK_LEN_RESET = 8'd200;

   typedef struct packed {
      logic busy;
      logic done;
   } mcba_div_stat_type;

endpackage

// File: design/mcba_div.sv
// Serial restoring divider: 24-bit sum by 8-bit count, one quotient bit per cycle.
`timescale 1ns / 1ps
module mcba_div
   import mcba_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [SUM_WIDTH-1:0]   dividend,
   input  logic [COUNT_WIDTH-1:0] divisor,
   output logic [SUM_WIDTH-1:0]   quotient,
   output mcba_div_stat_type      stat
);

   localparam logic [DIV_CNT_WIDTH-1:0] STEPS = DIV_CNT_WIDTH'(SUM_WIDTH);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_CNT_WIDTH-1:0] step_ff, step_in;
   logic [SUM_WIDTH-1:0]     quo_ff, quo_in;
   logic [COUNT_WIDTH-1:0]   rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0]   dvs_ff, dvs_in;
   logic [COUNT_WIDTH:0]     shifted;
   logic [COUNT_WIDTH+1:0]   diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[SUM_WIDTH-1]};
      diff    = {1'b0, shifted} - {2'b00, dvs_ff};
      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         step_in = STEPS;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // take the difference when it does not borrow
         if (!diff[COUNT_WIDTH+1]) begin
            rem_in = diff[COUNT_WIDTH-1:0];
            quo_in = {quo_ff[SUM_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[COUNT_WIDTH-1:0];
            quo_in = {quo_ff[SUM_WIDTH-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == DIV_CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// File: design/multichannel_block_averager_top.sv
// Top level of the multichannel block averager (per-channel boxcar average and decimate).
`timescale 1ns / 1ps
// Each input word carries one converter sample and its channel. The sample, scaled by 16,
// is added into that channel's running sum and the channel's count advances. Once the new count
// reaches or passes block_length (set on the csr port, 200 after reset) the block emits one
// word with the channel and floor(sum / count) << 15, and clears that channel. Channels at or
// above NUM_CHANNELS are dropped without any effect. Timing: a word is taken in one cycle and
// its sum and count are updated in the next. A sample that closes a block then runs the serial
// divider, one quotient bit per cycle over the 24-bit sum, and then loads the output register;
// the load waits while a previous result is still held by rsp_tready low. req_tready stays low
// during the whole item. The output register lets the next item start while an earlier result
// waits to be taken. block_length is to be written only while idle; the block itself does not
// enforce this.
`include "multichannel_block_averager_top_assert.svh"
module multichannel_block_averager_top
   import mcba_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)(
   input  logic                       clock,
   input  logic                       reset,
   // req_tdata: channel [2:0], sample [14:3], zero fill [15]
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   // rsp_tdata: out_channel [2:0], average_value [33:3], zero fill [39:34]
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // block_length write port
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [COUNT_WIDTH-1:0]     csr_wdata
);

   localparam int IDX_WIDTH = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [CHAN_WIDTH:0] CH_LIMIT = (CHAN_WIDTH + 1)'(NUM_CHANNELS);
   localparam int FILL_WIDTH = RSP_TDATA_WIDTH - AVG_WIDTH - CHAN_WIDTH;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;  // wait for a sample
   localparam logic [1:0] ST_ACC  = 2'd1;  // read-modify-write of the channel state
   localparam logic [1:0] ST_DIV  = 2'd2;  // serial division, then load the result

   logic [1:0]              state_ff, state_in;
   logic [COUNT_WIDTH-1:0]  block_len_ff;
   logic [CHAN_WIDTH-1:0]   ch_ff;
   logic [SAMPLE_WIDTH-1:0] sample_ff;

   logic [SUM_WIDTH-1:0]    sum_ff [NUM_CHANNELS];
   logic [COUNT_WIDTH-1:0]  cnt_ff [NUM_CHANNELS];

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAN_WIDTH-1:0]   och_ff;
   logic [AVG_WIDTH-1:0]    avg_ff;

   logic [IDX_WIDTH-1:0]    idx;
   logic                    ch_ok;
   logic [SUM_WIDTH-1:0]    sum_new;
   logic [COUNT_WIDTH-1:0]  cnt_new;
   logic                    emit;
   logic                    acc_write;
   logic                    div_start;
   logic                    rsp_free;
   logic                    rsp_load;
   logic [SUM_WIDTH-1:0]    quotient;
   mcba_div_stat_type       div_stat;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   // channel lookup and the accumulate step
   always_comb begin
      idx     = ch_ff[IDX_WIDTH-1:0];
      ch_ok   = ({1'b0, ch_ff} < CH_LIMIT);
      sum_new = sum_ff[idx] + {{(SUM_WIDTH - SAMPLE_WIDTH - 4){1'b0}}, sample_ff, 4'b0000};
      cnt_new = cnt_ff[idx] + 1'b1;
      emit    = (cnt_new >= block_len_ff);
   end

   assign acc_write = (state_ff == ST_ACC) && ch_ok;
   assign div_start = acc_write && emit;
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_load  = (state_ff == ST_DIV) && div_stat.done && rsp_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            state_in = div_start ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold a result until it is taken, then free the slot
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         block_len_ff <= BLOCK_LEN_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            block_len_ff <= csr_wdata;
         end
      end
   end

   // per-channel sums and counts; a closing sample clears its channel
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            sum_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end
      end else if (acc_write) begin
         sum_ff[idx] <= emit ? '0 : sum_new;
         cnt_ff[idx] <= emit ? '0 : cnt_new;
      end
   end

   // capture the accepted word and the outgoing result
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         ch_ff     <= req_tdata[CHAN_WIDTH-1:0];
         sample_ff <= req_tdata[CHAN_WIDTH +: SAMPLE_WIDTH];
      end
      if (rsp_load) begin
         och_ff <= ch_ff;
         avg_ff <= {quotient[MEAN_WIDTH-1:0], {MEAN_SHIFT{1'b0}}};
      end
   end

   mcba_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_new),
      .divisor  (cnt_new),
      .quotient (quotient),
      .stat     (div_stat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{FILL_WIDTH{1'b0}}, avg_ff, och_ff};

   // the divider is never running while a new word can be taken
   `MCBA_ASSERT_SAME(a_idle_div_quiet, clock, reset, req_tready, !div_stat.busy)
   // an accepted word is always processed in the next cycle
   `MCBA_ASSERT_NEXT(a_accept_to_acc, clock, reset, req_tvalid && req_tready, state_ff == ST_ACC)
   // a finished quotient with a free slot shows up on the output
   `MCBA_ASSERT_NEXT(a_load_shows, clock, reset, rsp_load, rsp_valid_ff && state_ff == ST_IDLE)

endmodule

// File: sim/mcba_checker.sv
// Scoreboard for the multichannel block averager: predicts block averages and checks result words.
`timescale 1ns / 1ps
module mcba_checker
   import mcba_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [COUNT_WIDTH-1:0]     csr_wdata,
   output int                         mismatch_count,
   output int                         averages_pending
);

   typedef struct packed {
      logic [CHAN_WIDTH-1:0] chan;
      logic [AVG_WIDTH-1:0]  avg;
   } block_average_type;

   logic [SUM_WIDTH-1:0]   chan_sum   [NUM_CHANNELS];
   logic [COUNT_WIDTH-1:0] chan_count [NUM_CHANNELS];
   logic [COUNT_WIDTH-1:0] block_len;
   block_average_type      expected_averages [$];
   int                     errors = 0;

   // Add one sample to its channel; queue the block average once the block closes.
   function automatic void accumulate_sample(input logic [CHAN_WIDTH-1:0]   ch,
                                             input logic [SAMPLE_WIDTH-1:0] smp);
      logic [SUM_WIDTH-1:0]   total;
      logic [COUNT_WIDTH-1:0] n;
      logic [SUM_WIDTH-1:0]   mean;
      logic [39:0]            shifted;
      block_average_type      res;
      if (ch >= NUM_CHANNELS) return;
      total = chan_sum[ch] + {smp, 4'b0000};
      n     = chan_count[ch] + 1'b1;
      if (n < block_len) begin
         chan_sum[ch]   = total;
         chan_count[ch] = n;
      end else begin
         mean     = (n != 0) ? total / n : '0;
         shifted  = 40'(mean) << MEAN_SHIFT;
         res.chan = ch;
         res.avg  = shifted[AVG_WIDTH-1:0];
         expected_averages.push_back(res);
         chan_sum[ch]   = '0;
         chan_count[ch] = '0;
      end
   endfunction

   always @(posedge clock) begin
      block_average_type got;
      block_average_type want;
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            chan_sum[i]   = '0;
            chan_count[i] = '0;
         end
         block_len = BLOCK_LEN_RESET;
         expected_averages.delete();
      end else begin
         // compare before predicting: a word accepted now cannot answer itself
         if (rsp_tvalid && rsp_tready) begin
            got.chan = rsp_tdata[CHAN_WIDTH-1:0];
            got.avg  = rsp_tdata[CHAN_WIDTH +: AVG_WIDTH];
            if (expected_averages.size() == 0) begin
               $error("unexpected result word: out_channel %0d average_value %0d",
                      got.chan, got.avg);
               errors++;
            end else begin
               want = expected_averages.pop_front();
               if (got.chan !== want.chan) begin
                  $error("out_channel mismatch: expected %0d, actual %0d", want.chan, got.chan);
                  errors++;
               end
               if (got.avg !== want.avg) begin
                  $error("average_value mismatch: expected %0d, actual %0d", want.avg, got.avg);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready)
            accumulate_sample(req_tdata[CHAN_WIDTH-1:0], req_tdata[CHAN_WIDTH +: SAMPLE_WIDTH]);
         if (csr_valid && csr_ready)
            block_len = csr_wdata;
      end
      mismatch_count   <= errors;
      averages_pending <= expected_averages.size();
   end

endmodule

// File: sim/multichannel_block_averager_top_tb.sv
// Testbench top for the multichannel block averager: stimulus, idling and final verdict.
`timescale 1ns / 1ps
module multichannel_block_averager_top_tb
   import mcba_pkg::*;
();

   localparam int RESET_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 1_000_000; // far above the slowest legal run
   localparam int SETTLE_CYCLES = 40;        // covers a full divide plus output load
   localparam int DRAIN_LIMIT   = 5000;      // bound on waiting for outstanding averages

   logic                       clock;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [COUNT_WIDTH-1:0]     csr_wdata  = '0;

   int mismatch_count;
   int averages_pending;
   int cycle_count = 0;
   int stall_left  = 0;
   bit gaps_on     = 1'b0;  // insert idle cycles between request words
   bit stalls_on   = 1'b0;  // drop rsp_tready at random

   // 8 ns clock: 4 ns low, 4 ns high
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   multichannel_block_averager_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   mcba_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .averages_pending (averages_pending)
   );

   // Result-side backpressure: mostly short stalls, now and then a long one.
   // Compute the next level first so rsp_tready sees a single update per edge.
   always @(posedge clock) begin
      logic ready_next;
      int   pick;
      ready_next = 1'b1;
      if (stall_left > 0) begin
         stall_left--;
         ready_next = 1'b0;
      end else if (stalls_on && !reset) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            stall_left = $urandom_range(0, 2);
            ready_next = 1'b0;
         end else if (pick < 14) begin
            stall_left = $urandom_range(15, 79);
            ready_next = 1'b0;
         end
      end
      rsp_tready <= ready_next;
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Idle length before the next request word: mostly back to back, a few long gaps.
   function automatic int gap_length();
      int pick;
      if (!gaps_on) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Bias samples toward the rails so that sums hit their extremes.
   function automatic logic [SAMPLE_WIDTH-1:0] random_sample();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) return '0;
      if (pick < 20) return '1;
      return SAMPLE_WIDTH'($urandom_range(0, 4095));
   endfunction

   function automatic void set_idling(input int mode);
      gaps_on   = mode[0];
      stalls_on = mode[1];
   endfunction

   // Present one sample word and hold it until accepted. Leave tvalid high
   // afterwards so a back-to-back word needs no second update in this step.
   task automatic send_sample(input logic [CHAN_WIDTH-1:0] ch, input logic [SAMPLE_WIDTH-1:0] smp);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, smp, ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drop tvalid, drain every outstanding average, then let a divide in flight finish.
   task automatic wait_idle();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (averages_pending != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_block_length(input logic [COUNT_WIDTH-1:0] len);
      csr_valid <= 1'b1;
      csr_wdata <= len;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random samples spread over a window of span adjacent channels.
   task automatic random_phase(input int n_words, input int span);
      int base;
      base = $urandom_range(0, NUM_CHANNELS_DEF - span);
      for (int i = 0; i < n_words; i++)
         send_sample(CHAN_WIDTH'(base + $urandom_range(0, span - 1)), random_sample());
   endtask

   initial begin
      // hold reset, then release it once
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed: at the reset length of 200 three samples make no average
      set_idling(3);
      send_sample(3'd5, 12'h000);
      send_sample(3'd5, 12'hFFF);
      send_sample(3'd5, 12'hAAA);
      wait_idle();
      // lower the length below the count: channel 5 closes on its next sample
      write_block_length(8'd1);
      send_sample(3'd5, 12'h555);
      // length 1: every channel answers at once, samples cover rails and bit patterns
      send_sample(3'd0, 12'h000);
      send_sample(3'd1, 12'hFFF);
      send_sample(3'd2, 12'h555);
      send_sample(3'd3, 12'hAAA);
      send_sample(3'd4, 12'h001);
      send_sample(3'd5, 12'h800);
      send_sample(3'd6, 12'hFFE);
      send_sample(3'd7, 12'h007);
      wait_idle();
      // length 0: every sample is its own average
      write_block_length(8'd0);
      send_sample(3'd2, 12'hFFF);
      send_sample(3'd6, 12'h000);
      wait_idle();
      // length 2: pairs, with channels interleaved
      write_block_length(8'd2);
      send_sample(3'd7, 12'hFFF);
      send_sample(3'd7, 12'hFFF);
      send_sample(3'd0, 12'h000);
      send_sample(3'd1, 12'hFFF);
      send_sample(3'd0, 12'hFFF);
      wait_idle();

      // Longest block of full-scale samples: largest sum and largest average
      set_idling(0);
      write_block_length(8'd255);
      repeat (255) send_sample(3'd3, 12'hFFF);
      wait_idle();

      // Back to the reset length with random content on two channels
      set_idling(3);
      write_block_length(BLOCK_LEN_RESET);
      random_phase(250, 2);
      wait_idle();

      // Shortest lengths; leftover counts from above close on the first sample
      set_idling(1);
      write_block_length(8'd1);
      random_phase(150, NUM_CHANNELS_DEF);
      wait_idle();

      set_idling(2);
      write_block_length(8'd0);
      random_phase(60, NUM_CHANNELS_DEF);
      wait_idle();

      // Short blocks over random channel windows, each idling mode once
      for (int p = 0; p < 4; p++) begin
         set_idling(p);
         write_block_length(COUNT_WIDTH'($urandom_range(2, 12)));
         random_phase(90, $urandom_range(1, NUM_CHANNELS_DEF));
         wait_idle();
      end

      // Medium blocks concentrated on one or two channels
      for (int p = 0; p < 2; p++) begin
         set_idling(3 - p);
         write_block_length(COUNT_WIDTH'($urandom_range(13, 64)));
         random_phase(100, $urandom_range(1, 2));
         wait_idle();
      end

      // Any length at all on a single channel
      set_idling(3);
      write_block_length(COUNT_WIDTH'($urandom_range(0, 255)));
      random_phase(100, 1);
      wait_idle();

      if (mismatch_count == 0 && averages_pending == 0) begin
         $display("All tests passed");
      end else begin
         if (averages_pending != 0)
            $error("%0d expected averages never arrived", averages_pending);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
